// File: design/generational_handle_allocator_top_macros.svh
// Assertion macros for the generational handle allocator checker.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define GHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared constants and control/status types of the handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned INDEX_COUNT  = 1024;
  localparam int unsigned IDX_W        = $clog2(INDEX_COUNT);
  localparam int unsigned FRESH_W      = IDX_W + 1;
  localparam int unsigned GEN_W        = 8;
  localparam int unsigned TAG_W        = 4;
  localparam int unsigned CFG_W        = 10;
  localparam int unsigned CMP_W        = (IDX_W > CFG_W) ? IDX_W : CFG_W;
  localparam logic [CFG_W-1:0] MIN_FREE_RST = CFG_W'(64);

  typedef struct packed {
    logic clr_wr;        // clear one generation entry
    logic reuse_start;   // read free ring at tail, pop
    logic reuse_fetch;   // read generation of popped index
    logic retire_start;  // read generation of retired index
    logic retire_done;   // write generation, push ring, load result
    logic load_fresh;    // load result from fresh counter
    logic load_err;      // load exhausted-error result
    logic load_reuse;    // load result of a reused index
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic use_fresh;
    logic fresh_left;
    logic out_free;
  } stat_t;

endpackage

// File: design/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: clearing pass, request dispatch and result hand-off.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          func_i,
  input  gha_pkg::stat_t stat_i,
  output gha_pkg::cmd_t  cmd_o
);

  localparam int unsigned ST_W      = 3;
  localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
  localparam logic [ST_W-1:0] ST_FETCH  = 3'd2;
  localparam logic [ST_W-1:0] ST_REUSE  = 3'd3;
  localparam logic [ST_W-1:0] ST_RETIRE = 3'd4;

  logic [ST_W-1:0] state_q, state_d;
  logic            accept;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (func_i) begin
            cmd_o.retire_start = 1'b1;
            state_d            = ST_RETIRE;
          end else if (stat_i.use_fresh) begin
            if (stat_i.fresh_left) begin
              cmd_o.load_fresh = 1'b1;
            end else begin
              cmd_o.load_err = 1'b1;
            end
          end else begin
            cmd_o.reuse_start = 1'b1;
            state_d           = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.reuse_fetch = 1'b1;
        state_d           = ST_REUSE;
      end
      ST_REUSE: begin
        if (stat_i.out_free) begin
          cmd_o.load_reuse = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_RETIRE: begin
        if (stat_i.out_free) begin
          cmd_o.retire_done = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/gha_datapath.sv
// ----------------------------------------------------------------------------
// gha_datapath
// Free ring, generation memory, pointers, fresh counter and result register.
// ----------------------------------------------------------------------------
module gha_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gha_pkg::cmd_t                 cmd_i,
  output gha_pkg::stat_t                stat_o,
  input  logic                          cfg_valid_i,
  input  logic [gha_pkg::CFG_W-1:0]     cfg_min_free_i,
  input  logic [gha_pkg::TAG_W-1:0]     tag_i,
  input  logic [gha_pkg::IDX_W-1:0]     retire_index_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [gha_pkg::IDX_W-1:0]     index_o,
  output logic [gha_pkg::GEN_W-1:0]     generation_o,
  output logic [gha_pkg::TAG_W-1:0]     tag_out_o,
  output logic                          status_o
);

  logic [gha_pkg::CFG_W-1:0]   min_free_q;
  logic [gha_pkg::FRESH_W-1:0] next_fresh_q;
  logic [gha_pkg::IDX_W-1:0]   head_q, tail_q, clr_cnt_q;
  logic                        out_valid_q, out_valid_d;
  logic [gha_pkg::IDX_W-1:0]   pool;
  logic                        load_any;

  logic [gha_pkg::IDX_W-1:0]   ring_mem [gha_pkg::INDEX_COUNT];
  logic [gha_pkg::IDX_W-1:0]   ring_rdata_q;
  logic [gha_pkg::GEN_W-1:0]   gen_mem [gha_pkg::INDEX_COUNT];
  logic [gha_pkg::GEN_W-1:0]   gen_rdata_q;

  logic [gha_pkg::IDX_W-1:0]   idx_q;
  logic [gha_pkg::TAG_W-1:0]   tag_q;
  logic [gha_pkg::GEN_W-1:0]   gen_inc;
  logic                        gen_we, gen_re;
  logic [gha_pkg::IDX_W-1:0]   gen_waddr, gen_raddr;
  logic [gha_pkg::GEN_W-1:0]   gen_wdata;

  assign pool     = head_q - tail_q;
  assign gen_inc  = gen_rdata_q + gha_pkg::GEN_W'(1);
  assign load_any = cmd_i.load_fresh | cmd_i.load_err | cmd_i.load_reuse | cmd_i.retire_done;

  assign stat_o.clr_last   = (clr_cnt_q == '1);
  assign stat_o.use_fresh  = gha_pkg::CMP_W'(pool) < gha_pkg::CMP_W'(min_free_q);
  assign stat_o.fresh_left = !next_fresh_q[gha_pkg::IDX_W];
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign gen_we    = cmd_i.clr_wr | cmd_i.retire_done;
  assign gen_waddr = cmd_i.clr_wr ? clr_cnt_q : idx_q;
  assign gen_wdata = cmd_i.clr_wr ? '0 : gen_inc;
  assign gen_re    = cmd_i.retire_start | cmd_i.reuse_fetch;
  assign gen_raddr = cmd_i.retire_start ? retire_index_i : ring_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.retire_done) begin
      ring_mem[head_q] <= idx_q;
    end
    if (cmd_i.reuse_start) begin
      ring_rdata_q <= ring_mem[tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (gen_re) begin
      gen_rdata_q <= gen_mem[gen_raddr];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_any) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_free_q   <= gha_pkg::MIN_FREE_RST;
      next_fresh_q <= gha_pkg::FRESH_W'(1);
      head_q       <= '0;
      tail_q       <= '0;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        min_free_q <= cfg_min_free_i;
      end
      if (cmd_i.load_fresh) begin
        next_fresh_q <= next_fresh_q + gha_pkg::FRESH_W'(1);
      end
      if (cmd_i.retire_done) begin
        head_q <= head_q + gha_pkg::IDX_W'(1);
      end
      if (cmd_i.reuse_start) begin
        tail_q <= tail_q + gha_pkg::IDX_W'(1);
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + gha_pkg::IDX_W'(1);
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.retire_start) begin
      idx_q <= retire_index_i;
    end else if (cmd_i.reuse_fetch) begin
      idx_q <= ring_rdata_q;
    end
    if (cmd_i.reuse_start) begin
      tag_q <= tag_i;
    end
    if (cmd_i.load_fresh) begin
      index_o      <= next_fresh_q[gha_pkg::IDX_W-1:0];
      generation_o <= '0;
      tag_out_o    <= tag_i;
      status_o     <= 1'b0;
    end else if (cmd_i.load_err) begin
      index_o      <= '0;
      generation_o <= '0;
      tag_out_o    <= '0;
      status_o     <= 1'b1;
    end else if (cmd_i.load_reuse) begin
      index_o      <= idx_q;
      generation_o <= gen_rdata_q;
      tag_out_o    <= tag_q;
      status_o     <= 1'b0;
    end else if (cmd_i.retire_done) begin
      index_o      <= idx_q;
      generation_o <= gen_inc;
      tag_out_o    <= '0;
      status_o     <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/generational_handle_allocator_top.sv
// Fresh acquire or exhausted error: result registered at the accepting edge.
// Retire: generation memory read, then write-back; reuse acquire: free ring read, then
// generation memory read, then result load. One request in flight at a time.
// After reset a clearing pass zeroes the 1024-entry generation memory, one entry per
// cycle: no request is taken until the pass ends; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Allocator of index/generation/tag handles with a delayed-reuse free ring.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gha_pkg::CFG_W-1:0] cfg_min_free_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [gha_pkg::TAG_W-1:0] tag_i,
  input  logic [gha_pkg::IDX_W-1:0] retire_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [gha_pkg::IDX_W-1:0] index_o,
  output logic [gha_pkg::GEN_W-1:0] generation_o,
  output logic [gha_pkg::TAG_W-1:0] tag_out_o,
  output logic                      status_o
);

  gha_pkg::cmd_t  cmd;
  gha_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  gha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gha_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_min_free_i (cfg_min_free_i),
    .tag_i          (tag_i),
    .retire_index_i (retire_index_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .index_o        (index_o),
    .generation_o   (generation_o),
    .tag_out_o      (tag_out_o),
    .status_o       (status_o)
  );

endmodule

// File: design/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of the handle allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_top_macros.svh"

module gha_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      func_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [gha_pkg::IDX_W-1:0] index_o,
  input logic [gha_pkg::GEN_W-1:0] generation_o,
  input logic [gha_pkg::TAG_W-1:0] tag_out_o,
  input logic                      status_o
);

  `GHA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(index_o) && $stable(generation_o) && $stable(status_o), "stalled result changed")
  `GHA_ASSERT(a_err_zero, !(out_valid_o && status_o) || (index_o == '0 && generation_o == '0 && tag_out_o == '0), "error result carries a nonzero handle")
  `GHA_ASSERT_NEXT(a_retire_busy, in_valid_i && in_ready_o && func_i, !in_ready_o, "request taken during retire write-back")
  `GHA_ASSERT(a_ready_slot, !in_ready_o || !out_valid_o || out_ready_i, "request taken with result slot full")

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for generational_handle_allocator_top. A predictor of
// the handle allocator runs in step with the requests that the block accepts.
// Its expected handles are compared with the block's results, in order. The
// tests cover fresh and reused handles, retire of handles that are not live,
// generation wrap, free ring overflow and running out of fresh indexes.
// Random request streams run at several min_free settings, with random
// stalls on both sides at all but one of them.
// ----------------------------------------------------------------------------
module tb;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RETIRE  = 1'b1
  } op_e;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_EXHAUSTED = 1'b1;

  typedef struct packed {
    logic [gha_pkg::IDX_W-1:0] index;
    logic [gha_pkg::GEN_W-1:0] generation;
    logic [gha_pkg::TAG_W-1:0] tag;
    logic                      status;
  } handle_t;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      cfg_valid_i    = 1'b0;
  logic                      cfg_ready_o;
  logic [gha_pkg::CFG_W-1:0] cfg_min_free_i = '0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_ready_o;
  logic                      func_i         = OP_ACQUIRE;
  logic [gha_pkg::TAG_W-1:0] tag_i          = '0;
  logic [gha_pkg::IDX_W-1:0] retire_index_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i    = 1'b0;
  logic [gha_pkg::IDX_W-1:0] index_o;
  logic [gha_pkg::GEN_W-1:0] generation_o;
  logic [gha_pkg::TAG_W-1:0] tag_out_o;
  logic                      status_o;

  // allocator state as predicted
  bit [gha_pkg::FRESH_W-1:0] fresh_next = gha_pkg::FRESH_W'(1);
  bit [gha_pkg::IDX_W-1:0]   ring_wr_ptr;
  bit [gha_pkg::IDX_W-1:0]   ring_rd_ptr;
  bit [gha_pkg::IDX_W-1:0]   ring_slot [gha_pkg::INDEX_COUNT];
  bit                        slot_written [gha_pkg::INDEX_COUNT];
  bit [gha_pkg::GEN_W-1:0]   generation_of [gha_pkg::INDEX_COUNT];
  bit [gha_pkg::CFG_W-1:0]   min_free_q = gha_pkg::MIN_FREE_RST;

  handle_t                   pending_handles [$];
  logic [gha_pkg::IDX_W-1:0] live_handles [$];
  handle_t                   seen_h;
  handle_t                   want_h;
  int                        mismatch_count;
  int                        ready_hold;
  bit                        quiet;

  generational_handle_allocator_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_min_free_i (cfg_min_free_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .tag_i          (tag_i),
    .retire_index_i (retire_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .index_o        (index_o),
    .generation_o   (generation_o),
    .tag_out_o      (tag_out_o),
    .status_o       (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic handle_t predict_handle(op_e op, logic [gha_pkg::TAG_W-1:0] tag,
                                             logic [gha_pkg::IDX_W-1:0] ridx);
    handle_t h;
    bit [gha_pkg::IDX_W-1:0] pool;
    h = '0;
    pool = ring_wr_ptr - ring_rd_ptr;
    if (op == OP_RETIRE) begin
      generation_of[ridx] = generation_of[ridx] + 1'b1;
      ring_slot[ring_wr_ptr] = ridx;
      slot_written[ring_wr_ptr] = 1'b1;
      ring_wr_ptr = ring_wr_ptr + 1'b1;
      h.index = ridx;
      h.generation = generation_of[ridx];
    end else if (pool < min_free_q) begin
      if (fresh_next >= gha_pkg::INDEX_COUNT) begin
        h.status = ST_EXHAUSTED;
      end else begin
        h.index = fresh_next[gha_pkg::IDX_W-1:0];
        h.tag = tag;
        fresh_next = fresh_next + 1'b1;
      end
    end else begin
      h.index = ring_slot[ring_rd_ptr];
      ring_rd_ptr = ring_rd_ptr + 1'b1;
      h.generation = generation_of[h.index];
      h.tag = tag;
    end
    return h;
  endfunction

  // reuse path would pop a ring slot that was never filled
  function automatic bit reads_unwritten_slot();
    bit [gha_pkg::IDX_W-1:0] pool;
    pool = ring_wr_ptr - ring_rd_ptr;
    return pool >= min_free_q && !slot_written[ring_rd_ptr];
  endfunction

  task automatic report_mismatch(string what, handle_t want, handle_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected idx %0d gen %0d tag %0d status %0d", $time, what,
               want.index, want.generation, want.tag, want.status);
      $display("%0t %s: actual   idx %0d gen %0d tag %0d status %0d", $time, what,
               got.index, got.generation, got.tag, got.status);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_h = {index_o, generation_o, tag_out_o, status_o};
      if (pending_handles.size() == 0) begin
        report_mismatch("unexpected result", '0, seen_h);
      end else begin
        want_h = pending_handles.pop_front();
        if (seen_h !== want_h) report_mismatch("wrong result", want_h, seen_h);
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold != 0) begin
      out_ready_i <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      ready_hold <= pick_gap();
    end
  end

  task automatic send_request(input op_e op, input logic [gha_pkg::TAG_W-1:0] tag,
                              input logic [gha_pkg::IDX_W-1:0] ridx);
    int gap;
    handle_t h;
    gap = pick_gap();
    if (op == OP_ACQUIRE && reads_unwritten_slot()) begin
      op = OP_RETIRE;
      ridx = gha_pkg::IDX_W'($urandom_range(0, gha_pkg::INDEX_COUNT - 1));
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= op;
    tag_i          <= tag;
    retire_index_i <= ridx;
    do @(posedge clk_i); while (!in_ready_o);
    h = predict_handle(op, tag, ridx);
    pending_handles.push_back(h);
    if (op == OP_ACQUIRE && h.status == ST_OK) live_handles.push_back(h.index);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_handles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_min_free(input logic [gha_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_valid_i    <= 1'b1;
    cfg_min_free_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_free_q = value;
  endtask

  task automatic random_request();
    int r;
    int k;
    logic [gha_pkg::IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_request(OP_ACQUIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'($urandom));
    end else if (r < 90 && live_handles.size() != 0) begin
      k = $urandom_range(0, live_handles.size() - 1);
      idx = live_handles[k];
      live_handles.delete(k);
      send_request(OP_RETIRE, gha_pkg::TAG_W'($urandom), idx);
    end else begin
      send_request(OP_RETIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'($urandom));
    end
  endtask

  // reset min_free: fresh handles, retire of live, reserved and dead indexes
  task automatic test_fresh_and_retire();
    send_request(OP_ACQUIRE, '0, '1);
    send_request(OP_ACQUIRE, '1, '0);
    send_request(OP_RETIRE, '1, '0);
    send_request(OP_RETIRE, '0, '1);
    send_request(OP_RETIRE, 4'h5, gha_pkg::IDX_W'(1));
    send_request(OP_RETIRE, 4'ha, gha_pkg::IDX_W'(2));
    send_request(OP_ACQUIRE, 4'h9, '0);
  endtask

  task automatic test_reuse_order();
    set_min_free(gha_pkg::CFG_W'(1));
    repeat (5) begin
      send_request(OP_ACQUIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'($urandom));
    end
    send_request(OP_RETIRE, '0, gha_pkg::IDX_W'(4));
    send_request(OP_ACQUIRE, 4'h3, '0);
    set_min_free('0);
    send_request(OP_RETIRE, '0, gha_pkg::IDX_W'(3));
    send_request(OP_ACQUIRE, 4'hc, '1);
    send_request(OP_ACQUIRE, 4'h6, '0);
  endtask

  task automatic test_generation_wrap();
    set_min_free('1);
    repeat (257) send_request(OP_RETIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'(7));
  endtask

  task automatic test_random_traffic();
    bit [gha_pkg::CFG_W-1:0] settings [5];
    settings = '{gha_pkg::CFG_W'(0), gha_pkg::CFG_W'(1),
                 gha_pkg::CFG_W'($urandom_range(2, 40)), gha_pkg::MIN_FREE_RST, '1};
    foreach (settings[p]) begin
      set_min_free(settings[p]);
      quiet = (p == 2);
      repeat (150) random_request();
    end
    quiet = 1'b0;
  endtask

  task automatic test_ring_overflow();
    set_min_free('1);
    repeat (gha_pkg::INDEX_COUNT + 16) begin
      send_request(OP_RETIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'($urandom));
    end
    set_min_free('0);
    repeat (24) begin
      send_request(OP_ACQUIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'($urandom));
    end
  endtask

  task automatic test_fresh_exhaustion();
    int failed;
    failed = 0;
    set_min_free('1);
    for (int i = 0; i < gha_pkg::INDEX_COUNT + 8 && failed < 4; i++) begin
      if (fresh_next >= gha_pkg::INDEX_COUNT) failed++;
      send_request(OP_ACQUIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'($urandom));
    end
    set_min_free(gha_pkg::CFG_W'(1));
    repeat (6) begin
      send_request(OP_ACQUIRE, gha_pkg::TAG_W'($urandom), gha_pkg::IDX_W'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fresh_and_retire();
    test_reuse_order();
    test_generation_wrap();
    test_random_traffic();
    test_ring_overflow();
    test_fresh_exhaustion();
    wait_idle();
    if (mismatch_count == 0 && pending_handles.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
